[hw/rtl/bmpblit_pkg.sv]
// Shared types and constants for the bottom-up bitmap blitter.
// Used by the channel interfaces and every module of the block.
`default_nettype none

package bmpblit_pkg;

   localparam int SCREEN_WIDTH_DEF  = 800;
   localparam int SCREEN_HEIGHT_DEF = 480;

   localparam int BYTE_W   = 8;
   localparam int WIDTH_W  = 10;
   localparam int HEIGHT_W = 9;
   localparam int ADDR_W   = 19;
   localparam int PIXEL_W  = 24;
   localparam int PAD_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [WIDTH_W-1:0]  IMAGE_WIDTH_RST  = WIDTH_W'(800);
   localparam logic [HEIGHT_W-1:0] IMAGE_HEIGHT_RST = HEIGHT_W'(480);
   localparam logic [WIDTH_W-1:0]  ORIGIN_X_RST     = '0;
   localparam logic [HEIGHT_W-1:0] ORIGIN_Y_RST     = '0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_ORIGIN_X     = 2'd2,
      CSR_ORIGIN_Y     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_BLUE  = 2'd0,
      PHASE_GREEN = 2'd1,
      PHASE_RED   = 2'd2
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              frame_start;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  fb_address;
      logic [PIXEL_W-1:0] pixel_value;
      logic               last_pixel;
      logic               range_error;
   } rsp_type;

   typedef struct packed {
      logic [WIDTH_W-1:0]  image_width;
      logic [HEIGHT_W-1:0] image_height;
      logic [WIDTH_W-1:0]  origin_x;
      logic [HEIGHT_W-1:0] origin_y;
   } cfg_type;

endpackage

`default_nettype wire

[hw/rtl/bmpblit_if.sv]
// Valid/ready channel interfaces for the blitter's byte input and write output.
// Depends on bmpblit_pkg for field widths.
`default_nettype none

interface bmpblit_req_if;
   import bmpblit_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface bmpblit_rsp_if;
   import bmpblit_pkg::*;
   logic               valid;
   logic               ready;
   logic [ADDR_W-1:0]  fb_address;
   logic [PIXEL_W-1:0] pixel_value;
   logic               last_pixel;
   logic               range_error;

   modport source (output valid, output fb_address, output pixel_value,
                   output last_pixel, output range_error, input ready);
   modport sink   (input valid, input fb_address, input pixel_value,
                   input last_pixel, input range_error, output ready);
endinterface

`default_nettype wire

[hw/rtl/bmp_placed_padded_flip_blit_core.sv]
// Bottom-up 24-bit bitmap blitter: one pixel-data byte per request, one write per pixel
// when the image fits, else one range error per frame. Input register, then result register.
// Throughput: one request per cycle while the result register can take its result.
// Reset (synchronous, active high) clears counters and sets registers to 800x480 at 0,0.
// Depends on bmpblit_pkg, bmpblit_if, bmpblit_in_stage, bmpblit_walker, bmpblit_out_stage.
`default_nettype none

module bmp_placed_padded_flip_blit_core #(
   parameter int SCREEN_WIDTH  = bmpblit_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = bmpblit_pkg::SCREEN_HEIGHT_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   bmpblit_req_if.sink                              req_chan,
   bmpblit_rsp_if.source                            rsp_chan,
   input  wire logic                                csr_we,
   input  wire logic [bmpblit_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bmpblit_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bmpblit_pkg::*;

   cfg_type cfg_ff, cfg_in;
   req_type req_item, held_item;
   rsp_type walk_result, out_item;
   logic    held_valid, advance, emit, out_free, out_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_wdata[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_wdata[HEIGHT_W-1:0];
            CSR_ORIGIN_X:     cfg_in.origin_x     = csr_wdata[WIDTH_W-1:0];
            CSR_ORIGIN_Y:     cfg_in.origin_y     = csr_wdata[HEIGHT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{image_width: IMAGE_WIDTH_RST, image_height: IMAGE_HEIGHT_RST,
                     origin_x: ORIGIN_X_RST, origin_y: ORIGIN_Y_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_item = '{data_byte: req_chan.data_byte, frame_start: req_chan.frame_start};

   // advance the held request only when the result register can take its result
   assign advance = held_valid && out_free;

   bmpblit_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .in_item    (req_item),
      .advance    (advance),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   bmpblit_walker #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_walker (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (held_item),
      .cfg     (cfg_ff),
      .emit    (emit),
      .result  (walk_result)
   );

   bmpblit_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && emit),
      .load_item (walk_result),
      .free      (out_free),
      .out_valid (out_valid),
      .out_ready (rsp_chan.ready),
      .out_item  (out_item)
   );

   assign rsp_chan.valid       = out_valid;
   assign rsp_chan.fb_address  = out_item.fb_address;
   assign rsp_chan.pixel_value = out_item.pixel_value;
   assign rsp_chan.last_pixel  = out_item.last_pixel;
   assign rsp_chan.range_error = out_item.range_error;

   a_error_is_final : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.range_error) |->
         (rsp_chan.last_pixel && rsp_chan.fb_address == '0 && rsp_chan.pixel_value == '0))
      else $error("range error result is not a bare final result");

   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> (!held_valid || advance))
      else $error("request accepted over a held request");

   a_load_when_free : assert property (@(posedge clock) disable iff (reset)
      (advance && emit) |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result register overwritten while full");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> (!rsp_chan.valid && !held_valid))
      else $error("pipeline not empty after reset");
endmodule

`default_nettype wire

[hw/rtl/bmpblit_in_stage.sv]
// Input register of the blitter: holds one request until the walker takes it.
// Depends on bmpblit_pkg.
`default_nettype none

module bmpblit_in_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire bmpblit_pkg::req_type in_item,
   input  wire logic                 advance,
   output logic                      held_valid,
   output bmpblit_pkg::req_type      held_item
);
   import bmpblit_pkg::*;

   logic    valid_ff, valid_in;
   req_type item_ff, item_in;

   always_comb begin
      in_ready = !valid_ff || advance;
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
         item_in  = in_item;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;
endmodule

`default_nettype wire

[hw/rtl/bmpblit_walker.sv]
// Byte walker: pixel assembly, padding skip, row/column counters and the
// framebuffer address. Depends on bmpblit_pkg.
`default_nettype none

module bmpblit_walker #(
   parameter int SCREEN_WIDTH  = bmpblit_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = bmpblit_pkg::SCREEN_HEIGHT_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire bmpblit_pkg::req_type item,
   input  wire bmpblit_pkg::cfg_type cfg,
   output logic                      emit,
   output bmpblit_pkg::rsp_type      result
);
   import bmpblit_pkg::*;

   localparam int SW_W  = $clog2(SCREEN_WIDTH + 1);
   localparam int SH_W  = $clog2(SCREEN_HEIGHT + 1);
   localparam int CX_W  = ((SW_W > WIDTH_W + 1) ? SW_W : WIDTH_W + 1) + 1;
   localparam int CY_W  = ((SH_W > HEIGHT_W + 1) ? SH_W : HEIGHT_W + 1) + 1;
   localparam int MUL_W = HEIGHT_W + 1 + SW_W;
   localparam int SUM_W = ((MUL_W > ADDR_W) ? MUL_W : ADDR_W) + 1;

   phase_type           phase_ff, phase_in, eff_phase;
   logic [BYTE_W-1:0]   blue_ff, blue_in, eff_blue;
   logic [BYTE_W-1:0]   green_ff, green_in, eff_green;
   logic [WIDTH_W-1:0]  col_ff, col_in, eff_col, col_inc;
   logic [HEIGHT_W-1:0] row_ff, row_in, eff_row, row_inc;
   logic [PAD_W-1:0]    pad_ff, pad_in, eff_pad, pad_dec;
   logic                done_ff, done_in, eff_done;

   logic                fits, col_end, row_last, final_pixel, frame_end;
   logic [HEIGHT_W:0]   srow;
   logic [WIDTH_W:0]    scol;
   logic [SUM_W-1:0]    addr_sum;
   rsp_type             err_rsp;

   always_comb begin
      fits = (CX_W'(cfg.origin_x) + CX_W'(cfg.image_width) <= CX_W'(SCREEN_WIDTH)) &&
             (CY_W'(cfg.origin_y) + CY_W'(cfg.image_height) <= CY_W'(SCREEN_HEIGHT));

      // frame start clears the counters before this byte is taken
      if (item.frame_start) begin
         eff_phase = PHASE_BLUE;
         eff_blue  = '0;
         eff_green = '0;
         eff_col   = '0;
         eff_row   = '0;
         eff_pad   = '0;
         eff_done  = 1'b0;
      end else begin
         eff_phase = phase_ff;
         eff_blue  = blue_ff;
         eff_green = green_ff;
         eff_col   = col_ff;
         eff_row   = row_ff;
         eff_pad   = pad_ff;
         eff_done  = done_ff;
      end

      col_inc  = eff_col + WIDTH_W'(1);
      row_inc  = eff_row + HEIGHT_W'(1);
      pad_dec  = eff_pad - PAD_W'(1);
      col_end  = (col_inc >= cfg.image_width) || (col_inc == '0);
      row_last = (row_inc >= cfg.image_height) || (row_inc == '0);
      final_pixel = col_end &&
                    (({1'b0, eff_row} + (HEIGHT_W + 1)'(1)) >= {1'b0, cfg.image_height});

      srow = {1'b0, cfg.origin_y} + {1'b0, cfg.image_height} - (HEIGHT_W + 1)'(1)
             - {1'b0, eff_row};
      scol = {1'b0, cfg.origin_x} + {1'b0, eff_col};
      addr_sum = SUM_W'(srow) * SUM_W'(SCREEN_WIDTH) + SUM_W'(scol);

      err_rsp = '{fb_address: '0, pixel_value: '0, last_pixel: 1'b1, range_error: 1'b1};

      phase_in  = eff_phase;
      blue_in   = eff_blue;
      green_in  = eff_green;
      col_in    = eff_col;
      row_in    = eff_row;
      pad_in    = eff_pad;
      done_in   = eff_done;
      frame_end = 1'b0;
      emit      = 1'b0;
      result    = err_rsp;

      if (eff_done) begin
         // drop bytes until the next frame start
      end else if (cfg.image_width == '0 || cfg.image_height == '0) begin
         done_in = 1'b1;
         emit    = 1'b1;
      end else if (eff_row >= cfg.image_height) begin
         done_in = 1'b1;
      end else if (eff_pad != '0) begin
         pad_in = pad_dec;
         if (pad_dec == '0) begin
            col_in    = '0;
            row_in    = row_inc;
            frame_end = row_last;
            done_in   = row_last;
         end
         emit = frame_end && !fits;
      end else begin
         case (eff_phase)
            PHASE_BLUE: begin
               blue_in  = item.data_byte;
               phase_in = PHASE_GREEN;
            end
            PHASE_GREEN: begin
               green_in = item.data_byte;
               phase_in = PHASE_RED;
            end
            default: begin
               phase_in = PHASE_BLUE;
               col_in   = col_inc;
               if (col_end) begin
                  col_in = '0;
                  if (cfg.image_width[PAD_W-1:0] == '0) begin
                     row_in    = row_inc;
                     frame_end = row_last;
                     done_in   = row_last;
                  end else begin
                     pad_in = cfg.image_width[PAD_W-1:0];
                  end
               end
               if (fits) begin
                  emit = 1'b1;
                  result.fb_address  = addr_sum[ADDR_W-1:0];
                  result.pixel_value = {item.data_byte, eff_green, eff_blue};
                  result.last_pixel  = final_pixel;
                  result.range_error = 1'b0;
               end else begin
                  emit = frame_end;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_BLUE;
         blue_ff  <= '0;
         green_ff <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         pad_ff   <= '0;
         done_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         blue_ff  <= blue_in;
         green_ff <= green_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         pad_ff   <= pad_in;
         done_ff  <= done_in;
      end
   end
endmodule

`default_nettype wire

[hw/rtl/bmpblit_out_stage.sv]
// Result register of the blitter: holds one write or error result until taken.
// Depends on bmpblit_pkg.
`default_nettype none

module bmpblit_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire bmpblit_pkg::rsp_type load_item,
   output logic                      free,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output bmpblit_pkg::rsp_type      out_item
);
   import bmpblit_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type item_ff, item_in;

   always_comb begin
      free     = !valid_ff || out_ready;
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = load_item;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for bmp_placed_padded_flip_blit_core: bitmap pixel bytes in,
// framebuffer writes out, each write compared with a directed value or a behavioral predictor of the walker.
// Depends on bmpblit_pkg, bmpblit_if and the core's RTL.

module tb_top;
   import bmpblit_pkg::*;

   localparam int unsigned SCREEN_W        = SCREEN_WIDTH_DEF;
   localparam int unsigned SCREEN_H        = SCREEN_HEIGHT_DEF;
   localparam int unsigned RANDOM_ITEMS    = 1400;
   localparam int unsigned HOLD_CYCLES     = 300;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned CYCLE_LIMIT     = 300000;
   localparam int unsigned MAX_FRAME_BYTES = 150;
   localparam rsp_type RANGE_ERROR_WRITE =
      '{fb_address: '0, pixel_value: '0, last_pixel: 1'b1, range_error: 1'b1};

   typedef struct {
      bit                is_cfg;
      int unsigned       w, h, x, y;
      logic [BYTE_W-1:0] data_byte;
      logic              frame_start;
      bit                typed;
      rsp_type           want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bmpblit_req_if req_chan ();
   bmpblit_rsp_if rsp_chan ();

   bmp_placed_padded_flip_blit_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor copy of the registers and the byte walker
   cfg_type           cfg_shadow;
   phase_type         walk_phase;
   logic [BYTE_W-1:0] held_blue, held_green;
   int unsigned       walk_col, walk_row, pad_left;
   bit                frame_over;

   rsp_type      expected_writes[$];
   stim_row_type directed_rows[$];
   int unsigned  live_items;
   int unsigned  fail_count;
   int unsigned  cycle_count;
   int unsigned  send_idle_pct, stall_pct;
   int unsigned  hold_requests;

   function automatic void clear_walk();
      walk_phase = PHASE_BLUE;
      held_blue  = '0;
      held_green = '0;
      walk_col   = 0;
      walk_row   = 0;
      pad_left   = 0;
      frame_over = 1'b0;
   endfunction

   function automatic bit advance_row(input int unsigned h);
      walk_col = 0;
      walk_row = (walk_row + 1) & 'h1FF;
      if (walk_row >= h || walk_row == 0) begin
         frame_over = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void predict_write(input logic [BYTE_W-1:0] data_byte,
                                         input logic frame_start, output bit live,
                                         output bit produced, output rsp_type wr);
      int unsigned w, h, x, y, srow, scol, addr, pad;
      logic [PIXEL_W-1:0] pixel;
      bit fits, frame_end, row_end, final_px;
      w = cfg_shadow.image_width;
      h = cfg_shadow.image_height;
      x = cfg_shadow.origin_x;
      y = cfg_shadow.origin_y;
      live = 1'b0;
      produced = 1'b0;
      wr = '0;
      frame_end = 1'b0;
      if (frame_start) clear_walk();
      if (frame_over) return;
      live = 1'b1;
      if (w == 0 || h == 0) begin
         frame_over = 1'b1;
         produced = 1'b1;
         wr = RANGE_ERROR_WRITE;
         return;
      end
      // rows can run out when the height shrinks under a frame in progress
      if (walk_row >= h) begin
         frame_over = 1'b1;
         return;
      end
      fits = (x + w <= SCREEN_W) && (y + h <= SCREEN_H);
      if (pad_left != 0) begin
         pad_left = (pad_left - 1) & 3;
         if (pad_left == 0) frame_end = advance_row(h);
         if (frame_end && !fits) begin
            produced = 1'b1;
            wr = RANGE_ERROR_WRITE;
         end
         return;
      end
      if (walk_phase == PHASE_BLUE) begin
         held_blue = data_byte;
         walk_phase = PHASE_GREEN;
         return;
      end
      if (walk_phase == PHASE_GREEN) begin
         held_green = data_byte;
         walk_phase = PHASE_RED;
         return;
      end
      pixel = {data_byte, held_green, held_blue};
      srow = y + h - 1 - walk_row;
      scol = x + walk_col;
      addr = srow * SCREEN_W + scol;
      walk_phase = PHASE_BLUE;
      walk_col = (walk_col + 1) & 'h3FF;
      row_end = (walk_col >= w) || (walk_col == 0);
      final_px = row_end && (walk_row + 1 >= h);
      if (row_end) begin
         pad = w & 3;
         if (pad == 0) begin
            frame_end = advance_row(h);
         end else begin
            walk_col = 0;
            pad_left = pad;
         end
      end
      if (fits) begin
         produced = 1'b1;
         wr.fb_address  = addr[ADDR_W-1:0];
         wr.pixel_value = pixel;
         wr.last_pixel  = final_px;
         wr.range_error = 1'b0;
      end else if (frame_end) begin
         produced = 1'b1;
         wr = RANGE_ERROR_WRITE;
      end
   endfunction

   function automatic void add_cfg_row(input int unsigned w, h, x, y);
      stim_row_type row;
      row = '{default: '0};
      row.is_cfg = 1'b1;
      row.w = w;
      row.h = h;
      row.x = x;
      row.y = y;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_byte_row(input logic [BYTE_W-1:0] data_byte,
                                        input logic frame_start, input bit typed,
                                        input rsp_type want);
      stim_row_type row;
      row = '{default: '0};
      row.data_byte = data_byte;
      row.frame_start = frame_start;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_IMAGE_WIDTH:  cfg_shadow.image_width  = value;
         CSR_IMAGE_HEIGHT: cfg_shadow.image_height = value[HEIGHT_W-1:0];
         CSR_ORIGIN_X:     cfg_shadow.origin_x     = value;
         CSR_ORIGIN_Y:     cfg_shadow.origin_y     = value[HEIGHT_W-1:0];
         default: ;
      endcase
   endtask

   // Drop valid, then wait for every expected write and for bytes that give none to drain
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_cfg(input int unsigned w, h, x, y);
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, w[CSR_DATA_W-1:0]);
      write_csr(CSR_IMAGE_HEIGHT, h[CSR_DATA_W-1:0]);
      write_csr(CSR_ORIGIN_X, x[CSR_DATA_W-1:0]);
      write_csr(CSR_ORIGIN_Y, y[CSR_DATA_W-1:0]);
      csr_we <= 1'b0;
   endtask

   task automatic send_item(input logic [BYTE_W-1:0] data_byte, input logic frame_start,
                            input bit typed, input rsp_type want);
      bit live, produced;
      rsp_type wr;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.data_byte   <= data_byte;
      req_chan.frame_start <= frame_start;
      do @(posedge clock); while (!req_chan.ready);
      predict_write(data_byte, frame_start, live, produced, wr);
      if (typed) expected_writes.push_back(want);
      else if (produced) expected_writes.push_back(wr);
      if (live) live_items++;
   endtask

   // One frame of random bytes; oversized frames are cut short, some are broken off, some get trailing bytes
   task automatic run_frame(input logic opening_start);
      int unsigned w, h, len, noise;
      w = cfg_shadow.image_width;
      h = cfg_shadow.image_height;
      len = h * (3 * w + (w & 3));
      if (len == 0) len = $urandom_range(4, 1);
      if (len > MAX_FRAME_BYTES) len = $urandom_range(MAX_FRAME_BYTES, 30);
      else if ($urandom_range(99) < 8) len = $urandom_range(len, 1);
      for (int unsigned i = 0; i < len; i++)
         send_item($urandom_range(255), (i == 0) ? opening_start : ($urandom_range(199) == 0),
                   1'b0, '0);
      if ($urandom_range(3) == 0) begin
         noise = $urandom_range(4, 1);
         repeat (noise) send_item($urandom_range(255), 1'b0, 1'b0, '0);
      end
   endtask

   // Result side: random stalls, plus long hold-offs on request
   initial begin
      int unsigned holds_taken;
      holds_taken = 0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holds_taken != hold_requests) begin
            holds_taken++;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_writes.size() == 0) begin
            $error("unexpected write: fb_address %0d, pixel_value %06h",
                   rsp_chan.fb_address, rsp_chan.pixel_value);
            fail_count++;
         end else begin
            want = expected_writes.pop_front();
            if (rsp_chan.fb_address !== want.fb_address) begin
               $error("fb_address: expected %0d, actual %0d",
                      want.fb_address, rsp_chan.fb_address);
               fail_count++;
            end
            if (rsp_chan.pixel_value !== want.pixel_value) begin
               $error("pixel_value: expected %06h, actual %06h",
                      want.pixel_value, rsp_chan.pixel_value);
               fail_count++;
            end
            if (rsp_chan.last_pixel !== want.last_pixel) begin
               $error("last_pixel: expected %0b, actual %0b",
                      want.last_pixel, rsp_chan.last_pixel);
               fail_count++;
            end
            if (rsp_chan.range_error !== want.range_error) begin
               $error("range_error: expected %0b, actual %0b",
                      want.range_error, rsp_chan.range_error);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned kind, w, h, x, y, phase_idx, target, random_floor;
      logic opening;
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.data_byte   <= '0;
      req_chan.frame_start <= 1'b0;
      csr_we               <= 1'b0;
      csr_index            <= CSR_IMAGE_WIDTH;
      csr_wdata            <= '0;
      hold_requests        <= 0;
      send_idle_pct = 0;
      stall_pct = 0;
      cfg_shadow = '{image_width: IMAGE_WIDTH_RST, image_height: IMAGE_HEIGHT_RST,
                     origin_x: ORIGIN_X_RST, origin_y: ORIGIN_Y_RST};
      clear_walk();

      // Reset geometry, no frame start: first pixel lands on the bottom screen row
      add_byte_row(8'h01, 1'b0, 1'b0, '0);
      add_byte_row(8'h80, 1'b0, 1'b0, '0);
      add_byte_row(8'hFF, 1'b0, 1'b1, '{fb_address: 19'd383200, pixel_value: 24'hFF8001,
                                        last_pixel: 1'b0, range_error: 1'b0});
      add_byte_row(8'hFF, 1'b0, 1'b0, '0);
      add_byte_row(8'h00, 1'b0, 1'b0, '0);
      add_byte_row(8'h7E, 1'b0, 1'b0, '0);
      // One pixel in the far corner, one pad byte, then a byte after the frame
      add_cfg_row(1, 1, SCREEN_W - 1, SCREEN_H - 1);
      add_byte_row(8'h12, 1'b1, 1'b0, '0);
      add_byte_row(8'h34, 1'b0, 1'b0, '0);
      add_byte_row(8'h56, 1'b0, 1'b1, '{fb_address: 19'd383999, pixel_value: 24'h563412,
                                        last_pixel: 1'b1, range_error: 1'b0});
      add_byte_row(8'hAA, 1'b0, 1'b0, '0);
      add_byte_row(8'h55, 1'b0, 1'b0, '0);
      // Zero width: error on the first byte, the rest ignored
      add_cfg_row(0, 1, 0, 0);
      add_byte_row(8'h00, 1'b1, 1'b1, RANGE_ERROR_WRITE);
      add_byte_row(8'hFF, 1'b0, 1'b0, '0);
      // Off the right edge: error on the last pad byte
      add_cfg_row(2, 1, SCREEN_W - 1, 0);
      add_byte_row(8'h3C, 1'b1, 1'b0, '0);
      for (int i = 0; i < 6; i++) add_byte_row(8'(i * 37), 1'b0, 1'b0, '0);
      add_byte_row(8'hC3, 1'b0, 1'b1, RANGE_ERROR_WRITE);
      // Zero height
      add_cfg_row(4, 0, 0, 0);
      add_byte_row(8'h0F, 1'b1, 1'b1, RANGE_ERROR_WRITE);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_cfg)
            apply_cfg(directed_rows[i].w, directed_rows[i].h,
                      directed_rows[i].x, directed_rows[i].y);
         else
            send_item(directed_rows[i].data_byte, directed_rows[i].frame_start,
                      directed_rows[i].typed, directed_rows[i].want);
      end

      random_floor = live_items;
      phase_idx = 0;
      while (live_items < random_floor + RANDOM_ITEMS) begin
         kind = (phase_idx == 2) ? 0 : $urandom_range(9);
         w = $urandom_range(9, 1);
         h = $urandom_range(4, 1);
         x = $urandom_range(SCREEN_W - w);
         y = $urandom_range(SCREEN_H - h);
         if (kind == 6) begin
            // push one edge past the screen
            if ($urandom_range(1)) x = $urandom_range(SCREEN_W, SCREEN_W - w + 1);
            else y = $urandom_range(SCREEN_H, SCREEN_H - h + 1);
         end else if (kind == 7) begin
            x = SCREEN_W - w;
            y = SCREEN_H - h;
         end else if (kind == 8) begin
            if ($urandom_range(1)) w = 0;
            else h = 0;
         end else if (kind == 9) begin
            case ($urandom_range(3))
               0: begin w = SCREEN_W; h = SCREEN_H; x = 0; y = 0; end
               1: begin w = 1; h = 1; x = SCREEN_W; y = SCREEN_H; end
               2: begin w = SCREEN_W; h = 1; x = 0; y = 0; end
               default: begin
                  w = $urandom_range(1023);
                  h = $urandom_range(511);
                  x = $urandom_range(1023);
                  y = $urandom_range(511);
               end
            endcase
         end
         apply_cfg(w, h, x, y);

         case (phase_idx % 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 64; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 64; end
            default: begin send_idle_pct = 26; stall_pct = 26; end
         endcase
         // hold off the result side while requests keep coming
         if (phase_idx == 2) begin
            send_idle_pct = 0;
            hold_requests <= hold_requests + 1;
         end

         target = live_items + $urandom_range(140, 60);
         opening = ($urandom_range(99) >= 15);
         while (live_items < target) begin
            run_frame(opening);
            opening = 1'b1;
         end
         phase_idx++;
      end

      wait_idle();
      if (expected_writes.size() != 0) begin
         $error("%0d expected writes never arrived", expected_writes.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
